>>> hdl/mmbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmbu_pkg;

  // Item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_PUSH  = 2'd2;

  // Access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Register indexes on the config port
  localparam logic [2:0] REG_RAM_BASE     = 3'd0;
  localparam logic [2:0] REG_UART_DATA    = 3'd1;
  localparam logic [2:0] REG_UART_STATUS  = 3'd2;
  localparam logic [2:0] REG_TIMER_COUNT  = 3'd3;
  localparam logic [2:0] REG_TIMER_CMP    = 3'd4;
  localparam logic [2:0] REG_POWER        = 3'd5;

  // Power register commands
  localparam logic [7:0] POWER_HALT   = 8'h01;
  localparam logic [7:0] POWER_REBOOT = 8'h02;

  // UART status bits
  localparam logic [7:0] STATUS_TX_READY = 8'h02;
  localparam logic [7:0] STATUS_RX_READY = 8'h01;

  // Timer high half sits one word above the low half
  localparam logic [31:0] TIMER_HI_OFFSET = 32'd4;

  typedef struct packed {
    logic [31:0] ram_base;
    logic [31:0] uart_data_addr;
    logic [31:0] uart_status_addr;
    logic [31:0] timer_count_addr;
    logic [31:0] timer_compare_addr;
    logic [31:0] power_addr;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ram_base:           32'h8000_0000,
    uart_data_addr:     32'h1000_0000,
    uart_status_addr:   32'h1000_0005,
    timer_count_addr:   32'h0200_BFF8,
    timer_compare_addr: 32'h0200_4000,
    power_addr:         32'h0010_0000
  };

endpackage

`default_nettype wire

>>> hdl/mmbu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mmbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  input  wire logic                         re_i,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic      [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/memory_mapped_bus_with_uart_timer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Memory-mapped bus decoder with byte RAM, UART receive queue, split 64-bit
// timer registers and a power register. Each input beat is a bus read, a bus
// write or a received UART byte; each produces exactly one result beat.
// A small sequencer walks every RAM access one byte at a time through a single
// byte-wide RAM port and one address adder/decoder, so the input is stalled
// while an item is in work. A byte access, a register word access or a push
// takes one decode step; a halfword takes a decode step for each of its bytes;
// a word that hits RAM takes a decode step, then one RAM port access per byte.
// A finished result sits in an output register, so the next beat can be taken
// while the result still waits downstream. RAM and queue contents are not
// initialized; reading RAM before writing it returns garbage.

module memory_mapped_bus_with_uart_timer_unit #(
  parameter int RAM_BYTES = 65536,
  parameter int RX_DEPTH  = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input beats
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [7:0]  received_byte_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] read_data_o,
  output logic             transmit_valid_o,
  output logic      [7:0]  transmit_byte_o,
  output logic             halt_request_o,
  output logic             reboot_request_o
);

  localparam int AW = $clog2(RAM_BYTES);
  localparam int PW = $clog2(RX_DEPTH);

  // last legal offset for a 1-byte and a 4-byte span
  localparam logic [31:0] LimByte = 32'(RAM_BYTES - 1);
  localparam logic [31:0] LimWord = 32'(RAM_BYTES - 4);
  localparam logic [PW-1:0] PtrLast = PW'(RX_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1; // decode one byte step or a word
  localparam logic [1:0] S_RAMW = 2'd2; // word in RAM, one byte per cycle
  localparam logic [1:0] S_FIN  = 2'd3; // hand result to output register

  logic [1:0] state_q, state_d;

  mmbu_pkg::cfg_t cfg_q;

  // captured item
  logic [1:0]  kind_q, kind_d;
  logic [1:0]  size_q, size_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] wdata_q, wdata_d;
  logic [7:0]  rbyte_q, rbyte_d;

  // working result
  logic [31:0] rdata_q, rdata_d;
  logic        tx_valid_q, tx_valid_d;
  logic [7:0]  tx_byte_q, tx_byte_d;
  logic        halt_q, halt_d;
  logic        reboot_q, reboot_d;

  // step counter: halfword byte index or word RAM lane
  logic [1:0]    idx_q, idx_d;
  logic [AW-1:0] off_q, off_d;

  // outstanding registered reads and the lane they land in
  logic       pend_ram_q, pend_ram_d;
  logic       pend_rx_q, pend_rx_d;
  logic [1:0] pend_lane_q, pend_lane_d;

  // receive queue pointers and timers
  logic [PW-1:0] rx_wr_ptr_q, rx_wr_ptr_d;
  logic [PW-1:0] rx_rd_ptr_q, rx_rd_ptr_d;
  logic [63:0]   timer_count_q, timer_count_d;
  logic [63:0]   timer_cmp_q, timer_cmp_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rdata_q;
  logic        out_tx_valid_q;
  logic [7:0]  out_tx_byte_q;
  logic        out_halt_q;
  logic        out_reboot_q;
  logic        out_load;

  // shared address path
  logic [31:0] step_addr;
  logic [32:0] diff;
  logic        hit_byte, hit_word;
  logic [31:0] tc_hi_addr, tm_hi_addr;
  logic        rx_empty, rx_full;
  logic [7:0]  status_byte;
  logic [7:0]  step_wbyte;
  logic [7:0]  lane_wbyte;

  // memory ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          rx_we, rx_re;
  logic [7:0]    rx_rdata;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PtrLast) ? '0 : p + PW'(1);
    return r;
  endfunction

  // One adder and a range check serve every byte step and the word decode.
  assign step_addr = addr_q + 32'(idx_q);
  assign diff      = {1'b0, step_addr} - {1'b0, cfg_q.ram_base};
  assign hit_byte  = !diff[32] && (diff[31:0] <= LimByte);
  assign hit_word  = !diff[32] && (diff[31:0] <= LimWord);

  assign tc_hi_addr = cfg_q.timer_count_addr + mmbu_pkg::TIMER_HI_OFFSET;
  assign tm_hi_addr = cfg_q.timer_compare_addr + mmbu_pkg::TIMER_HI_OFFSET;

  assign rx_empty    = (rx_wr_ptr_q == rx_rd_ptr_q);
  assign rx_full     = (ptr_inc(rx_wr_ptr_q) == rx_rd_ptr_q);
  assign status_byte = mmbu_pkg::STATUS_TX_READY |
                       (rx_empty ? 8'h00 : mmbu_pkg::STATUS_RX_READY);

  assign step_wbyte = idx_q[0] ? wdata_q[15:8] : wdata_q[7:0];

  always_comb begin
    case (idx_q)
      2'd0:    lane_wbyte = wdata_q[7:0];
      2'd1:    lane_wbyte = wdata_q[15:8];
      2'd2:    lane_wbyte = wdata_q[23:16];
      default: lane_wbyte = wdata_q[31:24];
    endcase
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    size_d        = size_q;
    addr_d        = addr_q;
    wdata_d       = wdata_q;
    rbyte_d       = rbyte_q;
    rdata_d       = rdata_q;
    tx_valid_d    = tx_valid_q;
    tx_byte_d     = tx_byte_q;
    halt_d        = halt_q;
    reboot_d      = reboot_q;
    idx_d         = idx_q;
    off_d         = off_q;
    pend_ram_d    = 1'b0;
    pend_rx_d     = 1'b0;
    pend_lane_d   = pend_lane_q;
    rx_wr_ptr_d   = rx_wr_ptr_q;
    rx_rd_ptr_d   = rx_rd_ptr_q;
    timer_count_d = timer_count_q;
    timer_cmp_d   = timer_cmp_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = diff[AW-1:0];
    ram_wdata     = step_wbyte;
    rx_we         = 1'b0;
    rx_re         = 1'b0;

    // land read data issued last cycle
    if (pend_ram_q) begin
      rdata_d[{pend_lane_q, 3'b000} +: 8] = ram_rdata;
    end
    if (pend_rx_q) begin
      rdata_d[{pend_lane_q, 3'b000} +: 8] = rx_rdata;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d     = kind_i;
          size_d     = access_size_i;
          addr_d     = address_i;
          wdata_d    = write_data_i;
          rbyte_d    = received_byte_i;
          rdata_d    = '0;
          tx_valid_d = 1'b0;
          tx_byte_d  = '0;
          halt_d     = 1'b0;
          reboot_d   = 1'b0;
          idx_d      = '0;
          state_d    = S_DEC;
        end
      end

      S_DEC: begin
        state_d = S_FIN;
        if (kind_q == mmbu_pkg::KIND_PUSH) begin
          if (!rx_full) begin
            rx_we       = 1'b1;
            rx_wr_ptr_d = ptr_inc(rx_wr_ptr_q);
          end
        end else if ((kind_q == mmbu_pkg::KIND_READ || kind_q == mmbu_pkg::KIND_WRITE) &&
                     (size_q == mmbu_pkg::SIZE_BYTE || size_q == mmbu_pkg::SIZE_HALF)) begin
          // one byte access at step_addr
          if (hit_byte) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              ram_re      = 1'b1;
              pend_ram_d  = 1'b1;
              pend_lane_d = idx_q;
            end else begin
              ram_we = 1'b1;
            end
          end else if (step_addr == cfg_q.uart_data_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              if (!rx_empty) begin
                rx_re       = 1'b1;
                pend_rx_d   = 1'b1;
                pend_lane_d = idx_q;
                rx_rd_ptr_d = ptr_inc(rx_rd_ptr_q);
              end
            end else begin
              tx_valid_d = 1'b1;
              tx_byte_d  = step_wbyte;
            end
          end else if (step_addr == cfg_q.uart_status_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              rdata_d[{idx_q, 3'b000} +: 8] = status_byte;
            end
          end else if (step_addr == cfg_q.power_addr && kind_q == mmbu_pkg::KIND_WRITE) begin
            if (step_wbyte == mmbu_pkg::POWER_HALT) begin
              halt_d = 1'b1;
            end else if (step_wbyte == mmbu_pkg::POWER_REBOOT) begin
              reboot_d = 1'b1;
            end
          end
          if (size_q == mmbu_pkg::SIZE_HALF && idx_q == 2'd0) begin
            idx_d   = 2'd1;
            state_d = S_DEC;
          end
        end else if ((kind_q == mmbu_pkg::KIND_READ || kind_q == mmbu_pkg::KIND_WRITE) &&
                     size_q == mmbu_pkg::SIZE_WORD) begin
          if (hit_word) begin
            off_d   = diff[AW-1:0];
            idx_d   = '0;
            state_d = S_RAMW;
          end else if (step_addr == cfg_q.uart_data_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              if (!rx_empty) begin
                rx_re       = 1'b1;
                pend_rx_d   = 1'b1;
                pend_lane_d = 2'd0;
                rx_rd_ptr_d = ptr_inc(rx_rd_ptr_q);
              end
            end else begin
              tx_valid_d = 1'b1;
              tx_byte_d  = wdata_q[7:0];
            end
          end else if (step_addr == cfg_q.uart_status_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              rdata_d = {24'h0, status_byte};
            end
          end else if (step_addr == cfg_q.timer_count_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              rdata_d = timer_count_q[31:0];
            end else begin
              timer_count_d[31:0] = wdata_q;
            end
          end else if (step_addr == tc_hi_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              rdata_d = timer_count_q[63:32];
            end else begin
              timer_count_d[63:32] = wdata_q;
            end
          end else if (step_addr == cfg_q.timer_compare_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              rdata_d = timer_cmp_q[31:0];
            end else begin
              timer_cmp_d[31:0] = wdata_q;
            end
          end else if (step_addr == tm_hi_addr) begin
            if (kind_q == mmbu_pkg::KIND_READ) begin
              rdata_d = timer_cmp_q[63:32];
            end else begin
              timer_cmp_d[63:32] = wdata_q;
            end
          end else if (step_addr == cfg_q.power_addr && kind_q == mmbu_pkg::KIND_WRITE) begin
            if (wdata_q[7:0] == mmbu_pkg::POWER_HALT) begin
              halt_d = 1'b1;
            end else if (wdata_q[7:0] == mmbu_pkg::POWER_REBOOT) begin
              reboot_d = 1'b1;
            end
          end
        end
      end

      S_RAMW: begin
        ram_addr  = off_q;
        ram_wdata = lane_wbyte;
        if (kind_q == mmbu_pkg::KIND_READ) begin
          ram_re      = 1'b1;
          pend_ram_d  = 1'b1;
          pend_lane_d = idx_q;
        end else begin
          ram_we = 1'b1;
        end
        off_d = off_q + AW'(1);
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_q         <= mmbu_pkg::CFG_RESET;
      pend_ram_q    <= 1'b0;
      pend_rx_q     <= 1'b0;
      rx_wr_ptr_q   <= '0;
      rx_rd_ptr_q   <= '0;
      timer_count_q <= '0;
      timer_cmp_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      pend_ram_q    <= pend_ram_d;
      pend_rx_q     <= pend_rx_d;
      rx_wr_ptr_q   <= rx_wr_ptr_d;
      rx_rd_ptr_q   <= rx_rd_ptr_d;
      timer_count_q <= timer_count_d;
      timer_cmp_q   <= timer_cmp_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mmbu_pkg::REG_RAM_BASE:    cfg_q.ram_base           <= cfg_wdata_i;
          mmbu_pkg::REG_UART_DATA:   cfg_q.uart_data_addr     <= cfg_wdata_i;
          mmbu_pkg::REG_UART_STATUS: cfg_q.uart_status_addr   <= cfg_wdata_i;
          mmbu_pkg::REG_TIMER_COUNT: cfg_q.timer_count_addr   <= cfg_wdata_i;
          mmbu_pkg::REG_TIMER_CMP:   cfg_q.timer_compare_addr <= cfg_wdata_i;
          mmbu_pkg::REG_POWER:       cfg_q.power_addr         <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    size_q      <= size_d;
    addr_q      <= addr_d;
    wdata_q     <= wdata_d;
    rbyte_q     <= rbyte_d;
    rdata_q     <= rdata_d;
    tx_valid_q  <= tx_valid_d;
    tx_byte_q   <= tx_byte_d;
    halt_q      <= halt_d;
    reboot_q    <= reboot_d;
    idx_q       <= idx_d;
    off_q       <= off_d;
    pend_lane_q <= pend_lane_d;
    if (out_load) begin
      out_rdata_q    <= rdata_d;
      out_tx_valid_q <= tx_valid_q;
      out_tx_byte_q  <= tx_byte_q;
      out_halt_q     <= halt_q;
      out_reboot_q   <= reboot_q;
    end
  end

  mmbu_ram #(
    .WIDTH(8),
    .DEPTH(RAM_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  mmbu_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_rx_queue (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_wr_ptr_q),
    .wdata_i(rbyte_q),
    .re_i   (rx_re),
    .raddr_i(rx_rd_ptr_q),
    .rdata_o(rx_rdata)
  );

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_rdata_q;
  assign transmit_valid_o = out_tx_valid_q;
  assign transmit_byte_o  = out_tx_byte_q;
  assign halt_request_o   = out_halt_q;
  assign reboot_request_o = out_reboot_q;

`ifndef SYNTHESIS
  // a push into a full queue must drop the byte
  a_rx_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC && kind_q == mmbu_pkg::KIND_PUSH && rx_full) |=> $stable(rx_wr_ptr_q))
    else $error("receive queue overwritten while full");

  // read data only lands while the item is still in work
  a_pend_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_ram_q || pend_rx_q) |-> (state_q == S_DEC || state_q == S_RAMW || state_q == S_FIN))
    else $error("read data landed outside an item");

  // a result appears only out of the finish step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result without finished item");

  // word RAM lanes stay inside the array
  a_word_in_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RAMW) |-> (32'(off_q) <= LimByte))
    else $error("word RAM step out of range");
`endif

endmodule

`default_nettype wire

>>> sim/mmbu_check_pkg.sv
`timescale 1ns / 1ps

package mmbu_check_pkg;

  import mmbu_pkg::*;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned RXQ_DEPTH = 256;

  // Encodings that the block must treat as no-ops
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [7:0]  rx_byte;
  } bus_req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        halt;
    logic        reboot;
  } bus_rsp_t;

  // Tracks the decoder state and the result beats still owed by the block.
  class bus_result_tracker;
    cfg_t        cfg;
    logic [7:0]  mem [MEM_BYTES];
    bit          mem_written [MEM_BYTES];
    int unsigned written_offs [$];
    logic [7:0]  rxq [RXQ_DEPTH];
    int unsigned rx_head;
    int unsigned rx_tail;
    logic [63:0] count_reg;
    logic [63:0] compare_reg;
    bus_rsp_t    due_results [$];
    bus_rsp_t    acc;
    int unsigned mismatch_count;

    function new();
      cfg = CFG_RESET;
      rx_head = 0;
      rx_tail = 0;
      count_reg = '0;
      compare_reg = '0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_RAM_BASE:    cfg.ram_base = val;
        REG_UART_DATA:   cfg.uart_data_addr = val;
        REG_UART_STATUS: cfg.uart_status_addr = val;
        REG_TIMER_COUNT: cfg.timer_count_addr = val;
        REG_TIMER_CMP:   cfg.timer_compare_addr = val;
        REG_POWER:       cfg.power_addr = val;
        default: ;
      endcase
    endfunction

    // RAM offset when [a, a+len) sits wholly inside the window
    function bit mem_span(input logic [31:0] a, input int unsigned len,
                          output int unsigned off);
      logic [63:0] d;
      off = 0;
      if (a < cfg.ram_base) return 0;
      d = {32'd0, a} - {32'd0, cfg.ram_base};
      if (d + len > MEM_BYTES) return 0;
      off = d[31:0];
      return 1;
    endfunction

    function void mark_written(int unsigned off);
      if (!mem_written[off]) begin
        mem_written[off] = 1'b1;
        written_offs.push_back(off);
      end
    endfunction

    function void rx_push(logic [7:0] c);
      int unsigned nxt;
      nxt = (rx_tail + 1) % RXQ_DEPTH;
      if (nxt != rx_head) begin
        rxq[rx_tail] = c;
        rx_tail = nxt;
      end
    endfunction

    function logic [7:0] rx_pop();
      logic [7:0] c;
      if (rx_tail == rx_head) return 8'h00;
      c = rxq[rx_head];
      rx_head = (rx_head + 1) % RXQ_DEPTH;
      return c;
    endfunction

    function logic [7:0] status_byte();
      return STATUS_TX_READY | ((rx_tail != rx_head) ? STATUS_RX_READY : 8'h00);
    endfunction

    function logic [7:0] load_byte(logic [31:0] a);
      int unsigned off;
      if (mem_span(a, 1, off)) return mem[off];
      if (a == cfg.uart_data_addr) return rx_pop();
      if (a == cfg.uart_status_addr) return status_byte();
      return 8'h00;
    endfunction

    function logic [31:0] load_word(logic [31:0] a);
      int unsigned off;
      if (mem_span(a, 4, off)) return {mem[off + 3], mem[off + 2], mem[off + 1], mem[off]};
      if (a == cfg.uart_data_addr) return {24'd0, rx_pop()};
      if (a == cfg.uart_status_addr) return {24'd0, status_byte()};
      if (a == cfg.timer_count_addr) return count_reg[31:0];
      if (a == cfg.timer_count_addr + TIMER_HI_OFFSET) return count_reg[63:32];
      if (a == cfg.timer_compare_addr) return compare_reg[31:0];
      if (a == cfg.timer_compare_addr + TIMER_HI_OFFSET) return compare_reg[63:32];
      return '0;
    endfunction

    function void power_cmd(logic [7:0] v);
      if (v == POWER_HALT) acc.halt = 1'b1;
      else if (v == POWER_REBOOT) acc.reboot = 1'b1;
    endfunction

    function void store_byte(logic [31:0] a, logic [7:0] v);
      int unsigned off;
      if (mem_span(a, 1, off)) begin
        mark_written(off);
        mem[off] = v;
        return;
      end
      if (a == cfg.uart_data_addr) begin
        acc.tx_valid = 1'b1;
        acc.tx_byte = v;
        return;
      end
      if (a == cfg.power_addr) power_cmd(v);
    endfunction

    function void store_word(logic [31:0] a, logic [31:0] v);
      int unsigned off;
      if (mem_span(a, 4, off)) begin
        for (int i = 0; i < 4; i++) begin
          mark_written(off + i);
          mem[off + i] = v[8*i +: 8];
        end
        return;
      end
      if (a == cfg.uart_data_addr) begin
        acc.tx_valid = 1'b1;
        acc.tx_byte = v[7:0];
      end else if (a == cfg.timer_count_addr) begin
        count_reg[31:0] = v;
      end else if (a == cfg.timer_count_addr + TIMER_HI_OFFSET) begin
        count_reg[63:32] = v;
      end else if (a == cfg.timer_compare_addr) begin
        compare_reg[31:0] = v;
      end else if (a == cfg.timer_compare_addr + TIMER_HI_OFFSET) begin
        compare_reg[63:32] = v;
      end else if (a == cfg.power_addr) begin
        power_cmd(v[7:0]);
      end
    endfunction

    // False when a read would touch a RAM byte never written
    function bit read_defined(bus_req_t r);
      int unsigned off;
      if (r.kind != KIND_READ) return 1;
      case (r.size)
        SIZE_BYTE: return !mem_span(r.addr, 1, off) || mem_written[off];
        SIZE_HALF: begin
          if (mem_span(r.addr, 1, off) && !mem_written[off]) return 0;
          return !mem_span(r.addr + 32'd1, 1, off) || mem_written[off];
        end
        SIZE_WORD: begin
          if (!mem_span(r.addr, 4, off)) return 1;
          return mem_written[off] && mem_written[off + 1] &&
                 mem_written[off + 2] && mem_written[off + 3];
        end
        default: return 1;
      endcase
    endfunction

    // Apply one accepted access and queue the result beat it owes
    function void log_access(bus_req_t r);
      logic [7:0] lo;
      logic [7:0] hi;
      acc = '0;
      case (r.kind)
        KIND_READ: begin
          case (r.size)
            SIZE_BYTE: acc.rdata = {24'd0, load_byte(r.addr)};
            SIZE_HALF: begin
              lo = load_byte(r.addr);
              hi = load_byte(r.addr + 32'd1);
              acc.rdata = {16'd0, hi, lo};
            end
            SIZE_WORD: acc.rdata = load_word(r.addr);
            default: ;
          endcase
        end
        KIND_WRITE: begin
          case (r.size)
            SIZE_BYTE: store_byte(r.addr, r.wdata[7:0]);
            SIZE_HALF: begin
              store_byte(r.addr, r.wdata[7:0]);
              store_byte(r.addr + 32'd1, r.wdata[15:8]);
            end
            SIZE_WORD: store_word(r.addr, r.wdata);
            default: ;
          endcase
        end
        KIND_PUSH: rx_push(r.rx_byte);
        default: ;
      endcase
      due_results.push_back(acc);
    endfunction

    function void compare_result(bus_rsp_t got);
      bus_rsp_t want;
      if (due_results.size() == 0) begin
        $error("result beat with no access outstanding, read_data=%h", got.rdata);
        mismatch_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.rdata !== want.rdata) begin
        $error("read_data: expected %h, got %h", want.rdata, got.rdata);
        mismatch_count++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("transmit_valid: expected %b, got %b", want.tx_valid, got.tx_valid);
        mismatch_count++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("transmit_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
        mismatch_count++;
      end
      if (got.halt !== want.halt) begin
        $error("halt_request: expected %b, got %b", want.halt, got.halt);
        mismatch_count++;
      end
      if (got.reboot !== want.reboot) begin
        $error("reboot_request: expected %b, got %b", want.reboot, got.reboot);
        mismatch_count++;
      end
    endfunction
  endclass

endpackage

>>> sim/memory_mapped_bus_with_uart_timer_unit_test.sv
`timescale 1ns / 1ps

module memory_mapped_bus_with_uart_timer_unit_test;

  import mmbu_pkg::*;
  import mmbu_check_pkg::*;

  // Traffic mixes for the random blocks
  typedef enum int {MIX_NORMAL, MIX_FLOOD, MIX_DRAIN} mix_e;

  localparam int BLOCK_BEATS = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [1:0]  access_size;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [7:0]  received_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        transmit_valid;
  logic [7:0]  transmit_byte;
  logic        halt_request;
  logic        reboot_request;

  bus_result_tracker tracker;
  bus_rsp_t          seen;
  bit                no_idle = 1'b0;  // disables gaps and stalls on both sides
  int                stall_left = 0;
  int                stall_roll;

  memory_mapped_bus_with_uart_timer_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .access_size_i    (access_size),
    .address_i        (address),
    .write_data_i     (write_data),
    .received_byte_i  (received_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_data_o      (read_data),
    .transmit_valid_o (transmit_valid),
    .transmit_byte_o  (transmit_byte),
    .halt_request_o   (halt_request),
    .reboot_request_o (reboot_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Downstream stall: mostly open, short bursts, an occasional long hold.
  always @(negedge clk) begin
    if (no_idle || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // Result monitor: a beat moves on a rising edge with valid high and no stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.rdata    = read_data;
      seen.tx_valid = transmit_valid;
      seen.tx_byte  = transmit_byte;
      seen.halt     = halt_request;
      seen.reboot   = reboot_request;
      tracker.compare_result(seen);
    end
  end

  // Upstream gap before a beat: usually none, sometimes a few, rarely long
  function automatic int idle_len();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one beat at a falling edge and hold it until the block takes it.
  task automatic send_access(bus_req_t r);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= r.kind;
    access_size   <= r.size;
    address       <= r.addr;
    write_data    <= r.wdata;
    received_byte <= r.rx_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.log_access(r);
  endtask

  task automatic issue(logic [1:0] k, logic [1:0] s, logic [31:0] a, logic [31:0] d,
                       logic [7:0] b);
    bus_req_t r;
    r.kind    = k;
    r.size    = s;
    r.addr    = a;
    r.wdata   = d;
    r.rx_byte = b;
    send_access(r);
  endtask

  // Drop valid and wait until every owed result beat has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  // Back-to-back register writes; enable stays high across the burst
  task automatic write_cfg(cfg_t c);
    logic [2:0]  ids  [6];
    logic [31:0] vals [6];
    ids  = '{REG_RAM_BASE, REG_UART_DATA, REG_UART_STATUS,
             REG_TIMER_COUNT, REG_TIMER_CMP, REG_POWER};
    vals = '{c.ram_base, c.uart_data_addr, c.uart_status_addr,
             c.timer_count_addr, c.timer_compare_addr, c.power_addr};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= ids[i];
      cfg_wdata <= vals[i];
      tracker.set_reg(ids[i], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random access aimed at the decoder's targets under the current map
  function automatic bus_req_t make_access(mix_e mix);
    bus_req_t    r;
    cfg_t        c;
    int unsigned roll;
    int unsigned spot;
    int unsigned off;
    c = tracker.cfg;
    r.wdata   = $urandom();
    r.rx_byte = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    spot = $urandom_range(0, 15);
    case (mix)
      MIX_FLOOD: r.kind = (roll < 95) ? KIND_PUSH : ((roll < 98) ? KIND_READ : KIND_WRITE);
      MIX_DRAIN: begin
        r.kind = (roll < 70) ? KIND_READ : KIND_WRITE;
        if (roll < 60) spot = 6;
      end
      default: r.kind = (roll < 3) ? KIND_NONE : (roll < 38) ? KIND_READ :
                        (roll < 75) ? KIND_WRITE : KIND_PUSH;
    endcase
    roll = $urandom_range(0, 99);
    r.size = (roll < 3) ? SIZE_NONE : (roll < 35) ? SIZE_BYTE :
             (roll < 60) ? SIZE_HALF : SIZE_WORD;
    case (spot)
      0, 1, 2, 3: begin
        // reads revisit written bytes; writes cluster at both ends of the window
        if (r.kind == KIND_READ && tracker.written_offs.size() != 0)
          off = tracker.written_offs[$urandom_range(0, tracker.written_offs.size() - 1)];
        else if (spot[0])
          off = $urandom_range(0, 63);
        else
          off = MEM_BYTES - 1 - $urandom_range(0, 7);
        r.addr = c.ram_base + off;
      end
      4:  r.addr = c.ram_base + $urandom_range(0, MEM_BYTES - 1);
      5:  r.addr = c.ram_base - 32'($urandom_range(1, 4));
      6:  r.addr = c.uart_data_addr;
      7:  r.addr = c.uart_status_addr;
      8:  r.addr = c.timer_count_addr;
      9:  r.addr = c.timer_count_addr + TIMER_HI_OFFSET;
      10: r.addr = c.timer_compare_addr;
      11: r.addr = c.timer_compare_addr + TIMER_HI_OFFSET;
      12: r.addr = c.power_addr;
      13: r.addr = ($urandom_range(0, 1) ? c.power_addr : c.uart_data_addr) - 32'd1;
      default: r.addr = $urandom();
    endcase
    // small data bytes so power commands land often, also on the upper half
    if (r.kind == KIND_WRITE && $urandom_range(0, 3) == 0) begin
      r.wdata[7:0]  = 8'($urandom_range(0, 3));
      r.wdata[15:8] = 8'($urandom_range(0, 3));
    end
    // never read RAM bytes that hold nothing yet
    if (!tracker.read_defined(r)) begin
      r.size = SIZE_BYTE;
      if (!tracker.read_defined(r)) r.kind = KIND_WRITE;
    end
    return r;
  endfunction

  initial begin
    cfg_t        plan [5];
    mix_e        block_plan [5];
    logic [31:0] base;

    tracker       = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_RAM_BASE;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    kind          = KIND_READ;
    access_size   = SIZE_BYTE;
    address       = '0;
    write_data    = '0;
    received_byte = '0;
    out_stall     = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats under the reset map
    base = CFG_RESET.ram_base;
    issue(KIND_READ, SIZE_BYTE, CFG_RESET.uart_status_addr, '0, '0);  // empty queue
    issue(KIND_READ, SIZE_BYTE, CFG_RESET.uart_data_addr, '0, '0);    // pop of empty
    issue(KIND_PUSH, SIZE_BYTE, '0, '0, 8'hA5);
    issue(KIND_PUSH, SIZE_WORD, '0, '0, 8'h00);
    issue(KIND_PUSH, SIZE_HALF, '0, '0, 8'hFF);
    issue(KIND_READ, SIZE_WORD, CFG_RESET.uart_status_addr, '0, '0);
    issue(KIND_READ, SIZE_WORD, CFG_RESET.uart_data_addr, '0, '0);
    issue(KIND_READ, SIZE_HALF, CFG_RESET.uart_data_addr, '0, '0);    // pop + unmapped
    issue(KIND_WRITE, SIZE_BYTE, base, 32'hFFFF_FF5A, '0);            // only low byte
    issue(KIND_WRITE, SIZE_WORD, base + 32'd4, 32'hDEAD_BEEF, '0);
    issue(KIND_READ, SIZE_WORD, base + 32'd4, '0, '0);
    issue(KIND_READ, SIZE_BYTE, base, '0, '0);
    // halfword straddling the top of RAM, then a word only partly inside
    issue(KIND_WRITE, SIZE_HALF, base + MEM_BYTES - 1, 32'h0000_C3E1, '0);
    issue(KIND_READ, SIZE_BYTE, base + MEM_BYTES - 1, '0, '0);
    issue(KIND_WRITE, SIZE_WORD, base + MEM_BYTES - 2, 32'h1111_2222, '0);
    issue(KIND_WRITE, SIZE_WORD, CFG_RESET.timer_count_addr, 32'hFFFF_FFFF, '0);
    issue(KIND_WRITE, SIZE_WORD, CFG_RESET.timer_count_addr + TIMER_HI_OFFSET,
          32'h8000_0001, '0);
    issue(KIND_WRITE, SIZE_WORD, CFG_RESET.timer_compare_addr, 32'h0123_4567, '0);
    issue(KIND_READ, SIZE_WORD, CFG_RESET.timer_count_addr + TIMER_HI_OFFSET, '0, '0);
    issue(KIND_READ, SIZE_WORD, CFG_RESET.timer_compare_addr, '0, '0);
    issue(KIND_READ, SIZE_BYTE, CFG_RESET.timer_count_addr, '0, '0);  // narrow timer
    issue(KIND_WRITE, SIZE_WORD, CFG_RESET.uart_data_addr, 32'h1234_5678, '0);
    issue(KIND_WRITE, SIZE_BYTE, CFG_RESET.power_addr, {24'd0, POWER_HALT}, '0);
    issue(KIND_WRITE, SIZE_WORD, CFG_RESET.power_addr, {24'hFFFFFF, POWER_REBOOT}, '0);
    issue(KIND_READ, SIZE_WORD, CFG_RESET.power_addr, '0, '0);
    issue(KIND_NONE, SIZE_WORD, CFG_RESET.uart_data_addr, 32'h0000_0001, 8'h3C);
    issue(KIND_READ, SIZE_NONE, CFG_RESET.uart_status_addr, '0, '0);
    issue(KIND_WRITE, SIZE_NONE, CFG_RESET.uart_data_addr, 32'h0000_0041, '0);

    // Address maps: reset, RAM at the bottom, RAM ending at the top,
    // a one-byte window with wrapping neighbors, then a random map.
    plan[0] = CFG_RESET;
    plan[1] = '{ram_base: 32'h0000_0000, uart_data_addr: 32'h0001_0000,
                uart_status_addr: 32'h0001_0001, timer_count_addr: 32'hFFFF_FFFC,
                timer_compare_addr: 32'h0001_0004, power_addr: 32'hFFFF_FFFF};
    plan[2] = '{ram_base: 32'hFFFF_0000, uart_data_addr: 32'h0000_0000,
                uart_status_addr: 32'h0000_0000, timer_count_addr: 32'h0000_0010,
                timer_compare_addr: 32'h0000_0014, power_addr: 32'h0000_0001};
    plan[3] = '{ram_base: 32'hFFFF_FFFF, uart_data_addr: 32'hFFFF_FFFE,
                uart_status_addr: 32'hFFFF_FFFD, timer_count_addr: 32'h0000_0000,
                timer_compare_addr: 32'hFFFF_FFF8, power_addr: 32'hFFFF_FFFC};
    plan[4].ram_base           = $urandom();
    plan[4].uart_data_addr     = $urandom();
    plan[4].uart_status_addr   = $urandom_range(0, 1) ? plan[4].uart_data_addr + 32'd1
                                                      : $urandom();
    plan[4].timer_count_addr   = $urandom() & 32'hFFFF_FFFC;
    plan[4].timer_compare_addr = $urandom_range(0, 1)
                                 ? plan[4].timer_count_addr + TIMER_HI_OFFSET : $urandom();
    plan[4].power_addr         = $urandom_range(0, 1) ? plan[4].ram_base : $urandom();

    // Floods fill the receive queue to overflow; the second flood runs
    // with no gaps or stalls at all.
    block_plan = '{MIX_NORMAL, MIX_FLOOD, MIX_FLOOD, MIX_NORMAL, MIX_DRAIN};

    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        settle();
        write_cfg(plan[ph]);
      end
      for (int b = 0; b < 5; b++) begin
        no_idle = (b == 2);
        for (int n = 0; n < BLOCK_BEATS; n++) send_access(make_access(block_plan[b]));
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (tracker.mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
